### src/clfe_pkg.sv
// Shared constants and helpers for the CRLF line framer with echo reply.
// Depends on nothing; the top level and both testbench files import it.
`default_nettype none

package clfe_pkg;

	// Line buffer capacity in bytes.
	localparam int LINE_CAPACITY = 32;

	// Address width of the line buffer; a one-entry buffer still gets one bit.
	localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	// The fill count must hold LINE_CAPACITY itself.
	localparam int COUNT_W = $clog2(LINE_CAPACITY + 1);

	localparam int BYTE_W = 8;

	// Reply layout: fixed prefix text, one space, then the line data.
	localparam int PREFIX_LEN = 14;
	localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
	localparam int REPLY_MAX = PREFIX_LEN + 1 + LINE_CAPACITY;
	localparam int REPLY_W = $clog2(REPLY_MAX + 1);

	localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

	// Characters of "response text:".
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] ch;
		case (idx)
			4'd0: ch = 8'h72;  // r
			4'd1: ch = 8'h65;  // e
			4'd2: ch = 8'h73;  // s
			4'd3: ch = 8'h70;  // p
			4'd4: ch = 8'h6F;  // o
			4'd5: ch = 8'h6E;  // n
			4'd6: ch = 8'h73;  // s
			4'd7: ch = 8'h65;  // e
			4'd8: ch = 8'h20;  // space
			4'd9: ch = 8'h74;  // t
			4'd10: ch = 8'h65; // e
			4'd11: ch = 8'h78; // x
			4'd12: ch = 8'h74; // t
			4'd13: ch = 8'h3A; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

### src/clfe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module clfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/crlf_line_framer_echo_unit.sv
// Top level of the CRLF line framer with echo reply.
// Depends on clfe_pkg and on the line buffer RAM clfe_ram.
`default_nettype none

// Received bytes come in on the rx channel and are stored in a line buffer RAM
// until a carriage return followed by a line feed arrives. That pair starts the
// reply on the tx channel: "response text:", a space, then the stored bytes in
// arrival order, with last_of_run high on the final byte (the space when the
// line is empty). A byte after a carriage return that is not a line feed, or an
// ordinary byte arriving while the buffer already holds LINE_CAPACITY bytes,
// discards the line with no reply. An ordinary byte, a carriage return or a bad
// ending is taken without stalling rx. A line end keeps rx stalled while the
// reply sequencer issues one element per cycle, which a tx stall holds back
// whenever it meets a byte waiting in the output register, since the RAM read
// port and the one-entry read stage only advance when the output register is
// free or being taken. After the last element is issued, rx opens again while
// the final two reply bytes still drain through the read stage and output
// register.

module crlf_line_framer_echo_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rx_valid,
	output logic                              rx_stall,
	input  wire logic [clfe_pkg::BYTE_W-1:0]  rx_byte,
	output logic                              tx_valid,
	input  wire logic                         tx_stall,
	output logic      [clfe_pkg::BYTE_W-1:0]  tx_byte,
	output logic                              last_of_run
);

	import clfe_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_REPLY
	} state_t;

	localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(LINE_CAPACITY);
	localparam logic [REPLY_W-1:0] IDX_SPACE = REPLY_W'(PREFIX_LEN);
	localparam logic [REPLY_W-1:0] IDX_DATA0 = REPLY_W'(PREFIX_LEN + 1);

	state_t state_q;

	// Line bookkeeping.
	logic [COUNT_W-1:0] count_q;
	logic               cr_seen_q;

	// Reply sequencer.
	logic [REPLY_W-1:0] idx_q;
	logic [COUNT_W-1:0] len_q;

	// Read stage: one element in flight toward the output register.
	logic               valid_s1;
	logic               from_ram_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;

	// Output register.
	logic               tx_valid_q;
	logic [BYTE_W-1:0]  tx_byte_q;
	logic               last_q;

	logic               rx_take;
	logic               advance;
	logic               issue;
	logic               is_prefix;
	logic               is_space;
	logic               last_elem;
	logic [REPLY_W-1:0] data_off;
	logic [REPLY_W-1:0] final_idx;
	logic [BYTE_W-1:0]  const_byte;

	logic               wr_en;
	logic               rd_en;
	logic [BYTE_W-1:0]  rd_data;

	// Requests are taken only while no reply is being issued.
	assign rx_stall = (state_q != ST_IDLE);
	assign rx_take  = rx_valid && !rx_stall;

	// Store an ordinary byte when there is room.
	assign wr_en = rx_take && !cr_seen_q && (rx_byte != BYTE_CR) && (count_q < CAPACITY);

	// Advance the reply path when the output register is empty or being taken.
	assign advance = !tx_valid_q || !tx_stall;
	assign issue   = (state_q == ST_REPLY) && advance;

	assign is_prefix = (idx_q < IDX_SPACE);
	assign is_space  = (idx_q == IDX_SPACE);
	assign data_off  = idx_q - IDX_DATA0;
	assign final_idx = IDX_SPACE + REPLY_W'(len_q);
	assign last_elem = (idx_q == final_idx);
	assign rd_en     = issue && !is_prefix && !is_space;

	always_comb begin
		if (is_prefix) begin
			const_byte = prefix_char(idx_q[PREFIX_IDX_W-1:0]);
		end else begin
			const_byte = BYTE_SPACE;
		end
	end

	clfe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(rx_byte),
		.rd_en  (rd_en),
		.rd_addr(data_off[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cr_seen_q   <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			valid_s1    <= 1'b0;
			from_ram_s1 <= 1'b0;
			byte_s1     <= '0;
			last_s1     <= 1'b0;
			tx_valid_q  <= 1'b0;
			tx_byte_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			// Line tracking on each accepted request.
			if (rx_take) begin
				if (cr_seen_q) begin
					// Either a line end or a bad ending: clear the line.
					count_q   <= '0;
					cr_seen_q <= 1'b0;
					if (rx_byte == BYTE_LF) begin
						len_q   <= count_q;
						idx_q   <= '0;
						state_q <= ST_REPLY;
					end
				end else if (rx_byte == BYTE_CR) begin
					cr_seen_q <= 1'b1;
				end else if (count_q < CAPACITY) begin
					count_q <= count_q + 1'b1;
				end else begin
					// Overlong line: drop the byte and the line.
					count_q <= '0;
				end
			end

			if (advance) begin
				// Move the read stage into the output register.
				tx_valid_q <= valid_s1;
				tx_byte_q  <= from_ram_s1 ? rd_data : byte_s1;
				last_q     <= last_s1;

				// Load the next reply element into the read stage.
				valid_s1    <= issue;
				from_ram_s1 <= rd_en;
				byte_s1     <= const_byte;
				last_s1     <= last_elem;
			end

			if (issue) begin
				if (last_elem) begin
					state_q <= ST_IDLE;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign tx_valid    = tx_valid_q;
	assign tx_byte     = tx_byte_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

### sim/echo_reply_checker.sv
// Watches both channels of the CRLF line framer, predicts each echo reply and
// compares it byte by byte. Depends on clfe_pkg for widths and byte codes.
`timescale 1ns / 100ps

module echo_reply_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rx_valid,
	input  wire logic                        rx_stall,
	input  wire logic [clfe_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        tx_valid,
	input  wire logic                        tx_stall,
	input  wire logic [clfe_pkg::BYTE_W-1:0] tx_byte,
	input  wire logic                        last_of_run,
	output int                               fail_count,
	output int                               replies_owed,
	output int                               lines_echoed
);

	import clfe_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} reply_byte_t;

	localparam logic [8*PREFIX_LEN-1:0] PREFIX_TEXT = "response text:";

	logic [BYTE_W-1:0] line_buf [LINE_CAPACITY];
	logic [5:0]        line_len;
	logic              cr_open;
	reply_byte_t       reply_due [$];

	function automatic logic [BYTE_W-1:0] prefix_at(input int idx);
		return PREFIX_TEXT[8*(PREFIX_LEN-1-idx) +: 8];
	endfunction

	// Advance the line state by one received byte; queue the reply on CR LF.
	task automatic absorb_rx(input logic [BYTE_W-1:0] b);
		int i;
		if (cr_open) begin
			if (b == BYTE_LF) begin
				for (i = 0; i < PREFIX_LEN; i++)
					reply_due.push_back({prefix_at(i), 1'b0});
				reply_due.push_back({BYTE_SPACE, line_len == 0});
				for (i = 0; i < line_len; i++)
					reply_due.push_back({line_buf[i], (i + 1) == line_len});
				lines_echoed++;
			end
			line_len = '0;
			cr_open = 1'b0;
		end else if (b == BYTE_CR) begin
			cr_open = 1'b1;
		end else if (line_len < LINE_CAPACITY) begin
			line_buf[line_len[ADDR_W-1:0]] = b;
			line_len = line_len + 6'd1;
		end else begin
			line_len = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_byte_t want;
		if (!arst_n) begin
			line_len = '0;
			cr_open = 1'b0;
			reply_due.delete();
			fail_count = 0;
			lines_echoed = 0;
			replies_owed <= 0;
		end else begin
			if (tx_valid && !tx_stall) begin
				if (reply_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected reply byte %h last %b",
							$time, tx_byte, last_of_run);
					fail_count++;
				end else begin
					want = reply_due.pop_front();
					if (want.data !== tx_byte || want.last !== last_of_run) begin
						if (fail_count < 10)
							$display("%0t: expected byte %h last %b, got byte %h last %b",
								$time, want.data, want.last, tx_byte, last_of_run);
						fail_count++;
					end
				end
			end
			if (rx_valid && !rx_stall)
				absorb_rx(rx_byte);
			replies_owed <= reply_due.size();
		end
	end

endmodule

### sim/tb_top.sv
// Stimulus and verdict for the CRLF line framer with echo reply.
// Depends on clfe_pkg, crlf_line_framer_echo_unit and echo_reply_checker.
`timescale 1ns / 100ps

module tb_top;
	import clfe_pkg::*;

	localparam int ITEM_TARGET    = 400;
	localparam int CALM_TAIL      = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 24;

	// Shapes of byte sequences in the random part.
	typedef enum int {
		SEQ_LINE,
		SEQ_FULL_LINE,
		SEQ_OVERFLOW,
		SEQ_BAD_END,
		SEQ_NOISE
	} seq_kind_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              rx_valid = 1'b0;
	logic [BYTE_W-1:0] rx_byte  = '0;
	logic              tx_stall = 1'b0;
	wire logic              rx_stall;
	wire logic              tx_valid;
	wire logic [BYTE_W-1:0] tx_byte;
	wire logic              last_of_run;

	int fail_count;
	int replies_owed;
	int lines_echoed;

	int rx_gap_pct = 20;
	int tx_gap_pct = 20;
	int items_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	int overflow_lines = 0;
	int bad_endings = 0;
	int noise_bursts = 0;
	int seq_n = 0;
	int pick;
	seq_kind_t kind;

	// Opening requests: empty line, extreme byte values, bad ending after a
	// line, CR followed by CR, and a bare line feed stored as ordinary data.
	logic [BYTE_W-1:0] opening_bytes [19] = '{
		BYTE_CR, BYTE_LF,
		8'h00, 8'hFF, BYTE_CR, BYTE_LF,
		8'h78, BYTE_CR, 8'h79, BYTE_CR, BYTE_LF,
		BYTE_CR, BYTE_CR, 8'h7A, BYTE_CR, BYTE_LF,
		BYTE_LF, BYTE_CR, BYTE_LF
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	crlf_line_framer_echo_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.tx_valid   (tx_valid),
		.tx_stall   (tx_stall),
		.tx_byte    (tx_byte),
		.last_of_run(last_of_run)
	);

	echo_reply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.tx_byte     (tx_byte),
		.last_of_run (last_of_run),
		.fail_count  (fail_count),
		.replies_owed(replies_owed),
		.lines_echoed(lines_echoed)
	);

	// Receiver back-pressure: raise stall at random, hold it while stall_left runs down.
	// With tx_gap_pct at zero no new stall burst starts.
	always @(posedge clk) begin
		if (!arst_n) begin
			tx_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			tx_stall <= 1'b1;
			stall_left <= $urandom_range(0, 16);
		end else begin
			tx_stall <= 1'b0;
		end
	end

	// Watchdog: count cycles with no request moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (tx_valid && !tx_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one received byte and hold it until the block takes it. A sender
	// gap drops valid first; otherwise valid stays high between requests.
	task automatic send_rx(input logic [BYTE_W-1:0] b);
		if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and hold off until every predicted reply byte has arrived.
	// The checker updates its count at the accepting edge, so read it only after that.
	task automatic drain_replies();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
	endtask

	// Line content never holds a carriage return, so the line runs to its end.
	function automatic logic [BYTE_W-1:0] line_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom_range(0, 255)); while (b == BYTE_CR);
		return b;
	endfunction

	task automatic send_sequence(input seq_kind_t k);
		int len;
		int i;
		logic [BYTE_W-1:0] b;
		case (k)
			SEQ_LINE, SEQ_FULL_LINE, SEQ_OVERFLOW: begin
				// Mostly short lines, else up to capacity; overlong lines exceed it.
				if (k == SEQ_FULL_LINE)
					len = LINE_CAPACITY;
				else if (k == SEQ_OVERFLOW)
					len = LINE_CAPACITY + $urandom_range(1, 12);
				else if ($urandom_range(0, 3) == 0)
					len = $urandom_range(0, LINE_CAPACITY);
				else
					len = $urandom_range(0, 8);
				for (i = 0; i < len; i++)
					send_rx(line_byte());
				send_rx(BYTE_CR);
				send_rx(BYTE_LF);
				if (k == SEQ_OVERFLOW)
					overflow_lines++;
			end
			SEQ_BAD_END: begin
				len = $urandom_range(0, 6);
				for (i = 0; i < len; i++)
					send_rx(line_byte());
				send_rx(BYTE_CR);
				do b = BYTE_W'($urandom_range(0, 255)); while (b == BYTE_LF);
				send_rx(b);
				bad_endings++;
			end
			default: begin
				// Raw bytes with CR and LF anywhere; may leave a CR pending.
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++)
					send_rx(BYTE_W'($urandom_range(0, 255)));
				noise_bursts++;
			end
		endcase
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i])
			send_rx(opening_bytes[i]);

		// Hold off the sender once until the replies have all drained.
		drain_replies();

		while (items_sent < ITEM_TARGET) begin
			// Re-pick idling odds now and then; run the tail with none at all.
			if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
				rx_gap_pct = 0;
				tx_gap_pct = 0;
			end else if (seq_n % 8 == 0) begin
				pick = $urandom_range(0, 3);
				rx_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : (pick == 2) ? 25 : 60;
				pick = $urandom_range(0, 3);
				tx_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : (pick == 2) ? 25 : 60;
			end

			// Walk every sequence shape once, then draw them by weight.
			if (seq_n <= int'(SEQ_NOISE)) begin
				kind = seq_kind_t'(seq_n);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					kind = SEQ_LINE;
				else if (pick < 60)
					kind = SEQ_FULL_LINE;
				else if (pick < 70)
					kind = SEQ_OVERFLOW;
				else if (pick < 85)
					kind = SEQ_BAD_END;
				else
					kind = SEQ_NOISE;
			end
			send_sequence(kind);
			if ($urandom_range(0, 19) == 0)
				drain_replies();
			seq_n++;
		end

		// Stop sending, wait out the last replies, then watch for strays.
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d sequences; %0d replies echoed", items_sent,
			seq_n, lines_echoed);
		$display("Discards: %0d overlong lines, %0d bad endings; %0d noise bursts",
			overflow_lines, bad_endings, noise_bursts);
		if (fail_count == 0 && replies_owed == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
